// ===== sv/mdl_pkg.sv =====
// shared types and constants for the baby-step giant-step discrete log unit
// no dependencies
`timescale 1ns / 1ps

package mdl_pkg;

  localparam int MOD_BITS     = 16;
  localparam int TABLE_DEPTH  = 512;
  localparam int ADDR_BITS    = $clog2(TABLE_DEPTH);
  localparam int ROOT_BITS    = MOD_BITS / 2;
  localparam int M_BITS       = ROOT_BITS + 1;
  localparam int JB_BITS      = MOD_BITS + 1;
  localparam int PROD_BITS    = 2 * MOD_BITS;
  localparam int RED_PER_CYC  = 4;
  localparam int RED_CYCLES   = PROD_BITS / RED_PER_CYC;
  localparam int RED_CNT_BITS = $clog2(RED_CYCLES + 1);

  // probe operations on the hash table
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic [MOD_BITS-1:0] base;
    logic [MOD_BITS-1:0] target;
    logic [MOD_BITS-1:0] modulus;
  } req_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] exponent;
    logic                found;
  } rsp_t;

  typedef struct packed {
    logic                valid;
    logic [MOD_BITS-1:0] key;
  } entry_t;

endpackage

// ===== sv/mdl_modmul.sv =====
// modular multiplier: one product, then restoring reduction four bits a cycle
// depends on mdl_pkg
`timescale 1ns / 1ps

module mdl_modmul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mdl_pkg::MOD_BITS-1:0] a,
  input  logic [mdl_pkg::MOD_BITS-1:0] b,
  input  logic [mdl_pkg::MOD_BITS-1:0] modulus,
  output logic                        done,
  output logic [mdl_pkg::MOD_BITS-1:0] result
);
  import mdl_pkg::*;

  logic [PROD_BITS-1:0]    prod;
  logic [MOD_BITS-1:0]     rem;
  logic [MOD_BITS-1:0]     rem_next;
  logic [MOD_BITS:0]       trial;
  logic [RED_CNT_BITS-1:0] cnt;
  logic                    run;

  // four shift-compare-subtract steps per cycle
  always_comb begin
    rem_next = rem;
    trial    = '0;
    for (int k = 0; k < RED_PER_CYC; k++) begin
      trial = {rem_next, prod[PROD_BITS-1-k]};
      if (trial >= {1'b0, modulus}) begin
        trial = trial - {1'b0, modulus};
      end
      rem_next = trial[MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        prod <= a * b;
        rem  <= '0;
        cnt  <= RED_CNT_BITS'(RED_CYCLES);
        run  <= 1'b1;
      end else if (run) begin
        rem  <= rem_next;
        prod <= prod << RED_PER_CYC;
        cnt  <= cnt - 1'b1;
        if (cnt == RED_CNT_BITS'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = rem;

endmodule

// ===== sv/mdl_table.sv =====
// hash table storage: one write port, one read port, registered read data
// depends on mdl_pkg
`timescale 1ns / 1ps

module mdl_table (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [mdl_pkg::ADDR_BITS-1:0] rd_addr,
  output mdl_pkg::entry_t               rd_data,
  input  logic                          wr_en,
  input  logic [mdl_pkg::ADDR_BITS-1:0] wr_addr,
  input  mdl_pkg::entry_t               wr_data
);
  import mdl_pkg::*;

  entry_t mem [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/modular_discrete_log_unit.sv =====
// discrete log by baby-step giant-step: sequencer, table and modular multiplier
// m = isqrt(p)+1 baby steps; a clearing pass over the hash table runs at the start of
// each query with a nonzero modulus, with the integer square root computed alongside
// one query at a time; a zero modulus skips the clearing pass and goes straight to the
// output state
// synchronous reset returns the sequencer to idle and empties the result register
`timescale 1ns / 1ps

module modular_discrete_log_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mdl_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mdl_pkg::rsp_t rsp
);
  import mdl_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_BMUL  = 4'd2;
  localparam logic [3:0] S_PRD   = 4'd3;
  localparam logic [3:0] S_PCHK  = 4'd4;
  localparam logic [3:0] S_PW0   = 4'd5;
  localparam logic [3:0] S_PWR   = 4'd6;
  localparam logic [3:0] S_PMUL  = 4'd7;
  localparam logic [3:0] S_PSQ   = 4'd8;
  localparam logic [3:0] S_GTEST = 4'd9;
  localparam logic [3:0] S_GMUL  = 4'd10;
  localparam logic [3:0] S_SCAN  = 4'd11;
  localparam logic [3:0] S_SCMUL = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]           state;
  logic [MOD_BITS-1:0]  x, t, p;
  logic [ROOT_BITS-1:0] sq, sq_bit, sq_try;
  logic [ADDR_BITS-1:0] clr, slot, probes;
  logic [M_BITS-1:0]    m, i, e, k;
  logic [MOD_BITS-1:0]  v, nxt, w, xm, pw, key;
  logic [JB_BITS-1:0]   jb, j;
  logic                 fail_seen, op;
  logic [MOD_BITS-1:0]  res_exp;
  logic                 res_found;
  logic [MOD_BITS-1:0]  one_p;

  logic                 mul_start, mul_done;
  logic [MOD_BITS-1:0]  mul_a, mul_b, mul_res;

  logic                 rd_en, wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  entry_t               rd_data, wr_data;

  assign one_p  = (p == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
  assign sq_try = sq | sq_bit;

  mdl_modmul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .modulus (p),
    .done    (mul_done),
    .result  (mul_res)
  );

  // table ports: clearing pass, probe reads, inserts into empty slots
  assign rd_en   = (state == S_PRD);
  assign wr_en   = (state == S_CLEAR) ||
                   (state == S_PCHK && op == OP_INSERT && !rd_data.valid);
  assign wr_addr = (state == S_CLEAR) ? clr : slot;
  assign wr_data = (state == S_CLEAR) ? entry_t'('0) : entry_t'{valid: 1'b1, key: key};

  mdl_table u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign req_stall = (state != S_IDLE);

  // query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mul_start <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            x      <= req.base;
            t      <= req.target;
            p      <= req.modulus;
            sq     <= '0;
            sq_bit <= {1'b1, {(ROOT_BITS-1){1'b0}}};
            clr    <= '0;
            if (req.modulus == '0) begin
              res_exp   <= '0;
              res_found <= 1'b0;
              state     <= S_OUT;
            end else begin
              state <= S_CLEAR;
            end
          end
        end
        // clear the table, integer square root alongside
        S_CLEAR: begin
          if (sq_bit != '0) begin
            if ({{ROOT_BITS{1'b0}}, sq_try} * {{ROOT_BITS{1'b0}}, sq_try} <= p) begin
              sq <= sq_try;
            end
            sq_bit <= sq_bit >> 1;
          end
          clr <= clr + 1'b1;
          if (clr == {ADDR_BITS{1'b1}}) begin
            m         <= {1'b0, sq} + 1'b1;
            i         <= M_BITS'(1);
            mul_a     <= x;
            mul_b     <= t;
            mul_start <= 1'b1;
            state     <= S_BMUL;
          end
        end
        // baby step product ready, insert it
        S_BMUL: begin
          if (mul_done) begin
            v      <= mul_res;
            key    <= mul_res;
            slot   <= mul_res[ADDR_BITS-1:0];
            probes <= '0;
            op     <= OP_INSERT;
            state  <= S_PRD;
          end
        end
        S_PRD: begin
          state <= S_PCHK;
        end
        // probe result: free slot, matching key, or step on
        S_PCHK: begin
          if (!rd_data.valid || rd_data.key == key || probes == {ADDR_BITS{1'b1}}) begin
            if (op == OP_INSERT) begin
              mul_start <= 1'b1;
              if (i == m) begin
                mul_a <= x;
                mul_b <= MOD_BITS'(1);
                state <= S_PW0;
              end else begin
                i     <= i + 1'b1;
                mul_a <= x;
                mul_b <= v;
                state <= S_BMUL;
              end
            end else if (rd_data.valid && rd_data.key == key) begin
              w     <= v;
              j     <= jb;
              k     <= '0;
              state <= S_SCAN;
            end else begin
              v     <= nxt;
              jb    <= jb + JB_BITS'(m);
              state <= S_GTEST;
            end
          end else begin
            slot   <= slot + 1'b1;
            probes <= probes + 1'b1;
            state  <= S_PRD;
          end
        end
        // x mod p ready, start the power x^m
        S_PW0: begin
          if (mul_done) begin
            pw    <= mul_res;
            xm    <= one_p;
            e     <= m;
            state <= S_PWR;
          end
        end
        S_PWR: begin
          if (e == '0) begin
            v         <= one_p;
            jb        <= '0;
            fail_seen <= 1'b0;
            state     <= S_GTEST;
          end else begin
            mul_start <= 1'b1;
            if (e[0]) begin
              mul_a <= xm;
              mul_b <= pw;
              state <= S_PMUL;
            end else begin
              mul_a <= pw;
              mul_b <= pw;
              state <= S_PSQ;
            end
          end
        end
        S_PMUL: begin
          if (mul_done) begin
            xm        <= mul_res;
            mul_a     <= pw;
            mul_b     <= pw;
            mul_start <= 1'b1;
            state     <= S_PSQ;
          end
        end
        S_PSQ: begin
          if (mul_done) begin
            pw    <= mul_res;
            e     <= e >> 1;
            state <= S_PWR;
          end
        end
        // giant step loop bound
        S_GTEST: begin
          if (jb >= {1'b0, p}) begin
            res_exp   <= '0;
            res_found <= 1'b0;
            state     <= S_OUT;
          end else begin
            mul_a     <= xm;
            mul_b     <= v;
            mul_start <= 1'b1;
            state     <= S_GMUL;
          end
        end
        S_GMUL: begin
          if (mul_done) begin
            nxt    <= mul_res;
            key    <= mul_res;
            slot   <= mul_res[ADDR_BITS-1:0];
            probes <= '0;
            op     <= OP_LOOKUP;
            state  <= S_PRD;
          end
        end
        // linear scan over one block after a hit
        S_SCAN: begin
          if (w == t) begin
            res_exp   <= j[MOD_BITS-1:0];
            res_found <= 1'b1;
            state     <= S_OUT;
          end else if (k == {1'b0, sq}) begin
            if (fail_seen) begin
              res_exp   <= '0;
              res_found <= 1'b0;
              state     <= S_OUT;
            end else begin
              fail_seen <= 1'b1;
              v         <= nxt;
              jb        <= jb + JB_BITS'(m);
              state     <= S_GTEST;
            end
          end else begin
            mul_a     <= x;
            mul_b     <= w;
            mul_start <= 1'b1;
            state     <= S_SCMUL;
          end
        end
        S_SCMUL: begin
          if (mul_done) begin
            w     <= mul_res;
            j     <= j + 1'b1;
            k     <= k + 1'b1;
            state <= S_SCAN;
          end
        end
        // hand the result to the output register once it is free
        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.exponent <= res_exp;
            rsp.found    <= res_found;
            rsp_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // multiplier completions only arrive while the sequencer waits for one
  a_mul_done_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_BMUL || state == S_PW0 || state == S_PMUL ||
                  state == S_PSQ || state == S_GMUL || state == S_SCMUL))
    else $error("multiplier result outside a wait state");

  // a not-found result carries a zero exponent
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.found) |-> (rsp.exponent == '0))
    else $error("not-found result with nonzero exponent");

  // a found exponent lies below the modulus of its query
  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && res_found) |-> (res_exp < p))
    else $error("exponent not below modulus");

  // inserts only go to slots read back as empty
  a_ins_empty: assert property (@(posedge clk) disable iff (rst)
    (wr_en && state == S_PCHK) |-> (op == OP_INSERT && !rd_data.valid))
    else $error("insert into occupied slot");

endmodule
